@@ hw/rtl/npal_pkg.sv @@
package npal_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int LAT_W       = 30;
  localparam int LON_W       = 31;
  localparam int ALT_IN_W    = 25;
  localparam int ALT_W       = 24;
  localparam int STATUS_W    = 3;
  localparam int COUNT_W     = 9;
  localparam int SQ_LAT_W    = 2 * LAT_W;
  localparam int SQ_LON_W    = 2 * LON_W;
  localparam int DIST_W      = SQ_LON_W + 1;

  localparam int S_TDATA_W   = 88;
  localparam int M_TDATA_W   = 40;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_STORED  = 3'd0,
    STATUS_IGNORED = 3'd1,
    STATUS_FULL    = 3'd2,
    STATUS_MATCHED = 3'd3,
    STATUS_EMPTY   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_LOAD,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [LAT_W-1:0] lat;
    logic [LON_W-1:0] lon;
    logic [ALT_W-1:0] alt;
  } entry_t;

  typedef struct packed {
    logic capture;
    logic scan_start;
    logic scan_issue;
    logic load_exec;
    logic push;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_query;
    logic count_zero;
    logic scan_last;
    logic pipe_busy;
    logic out_free;
  } dp_status_t;

endpackage

@@ hw/rtl/npal_ctrl.sv @@
module npal_ctrl
  import npal_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t stat,
  output ctrl_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (!stat.is_query) state_next = S_LOAD;
        else if (stat.count_zero) state_next = S_FINISH;
        else state_next = S_SCAN;
      end
      S_LOAD: begin
        state_next = S_FINISH;
      end
      S_SCAN: begin
        if (stat.scan_last) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (!stat.pipe_busy) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_DECIDE: begin
        cmd.scan_start = stat.is_query;
      end
      S_LOAD: begin
        cmd.load_exec = 1'b1;
      end
      S_SCAN: begin
        cmd.scan_issue = 1'b1;
      end
      S_FINISH: begin
        cmd.push = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

@@ hw/rtl/npal_dp.sv @@
module npal_dp
  import npal_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  ctrl_cmd_t           cmd,
  output dp_status_t          stat,
  input  logic                in_opcode,
  input  logic [LAT_W-1:0]    in_lat,
  input  logic [LON_W-1:0]    in_lon,
  input  logic [ALT_IN_W-1:0] in_alt,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [ALT_W-1:0]    out_alt,
  output logic [STATUS_W-1:0] out_status,
  output logic [COUNT_W-1:0]  out_count
);

  // captured item
  logic                q_op;
  logic [LAT_W-1:0]    q_lat;
  logic [LON_W-1:0]    q_lon;
  logic [ALT_IN_W-1:0] q_alt;

  logic [CNT_W-1:0]    count;
  status_t             load_status;
  logic                mem_we;
  logic                alt_pos;
  logic                table_full;

  entry_t              mem [TABLE_DEPTH];
  entry_t              rd_entry;
  logic [IDX_W-1:0]    scan_idx;

  // scan pipeline
  logic                v1, v2, v3, v4;
  logic signed [LAT_W:0] dlat_diff;
  logic signed [LON_W:0] dlon_diff;
  logic [LAT_W-1:0]    dlat;
  logic [LON_W-1:0]    dlon;
  logic [ALT_W-1:0]    alt2, alt3, alt4;
  logic [SQ_LAT_W-1:0] sq_lat;
  logic [SQ_LON_W-1:0] sq_lon;
  logic [DIST_W-1:0]   sq_sum;

  logic                have;
  logic [DIST_W-1:0]   best;
  logic [ALT_W-1:0]    best_alt;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      q_op  <= in_opcode;
      q_lat <= in_lat;
      q_lon <= in_lon;
      q_alt <= in_alt;
    end
  end

  assign alt_pos    = !q_alt[ALT_IN_W-1] && (q_alt != '0);
  assign table_full = (count == CNT_W'(TABLE_DEPTH));
  assign mem_we     = cmd.load_exec && alt_pos && !table_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (mem_we) begin
      count <= count + CNT_W'(1);
    end
  end

  // ignored check comes before the full check
  always_ff @(posedge clk) begin
    if (cmd.load_exec) begin
      if (!alt_pos) load_status <= STATUS_IGNORED;
      else if (table_full) load_status <= STATUS_FULL;
      else load_status <= STATUS_STORED;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count[IDX_W-1:0]] <= '{lat: q_lat, lon: q_lon, alt: q_alt[ALT_W-1:0]};
    end
    if (cmd.scan_issue) begin
      rd_entry <= mem[scan_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_idx <= '0;
    end else if (cmd.scan_issue) begin
      scan_idx <= scan_idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= cmd.scan_issue;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  assign dlat_diff = $signed({q_lat[LAT_W-1], q_lat})
                   - $signed({rd_entry.lat[LAT_W-1], rd_entry.lat});
  assign dlon_diff = $signed({q_lon[LON_W-1], q_lon})
                   - $signed({rd_entry.lon[LON_W-1], rd_entry.lon});

  always_ff @(posedge clk) begin
    dlat <= dlat_diff[LAT_W] ? LAT_W'(-dlat_diff) : LAT_W'(dlat_diff);
    dlon <= dlon_diff[LON_W] ? LON_W'(-dlon_diff) : LON_W'(dlon_diff);
    alt2 <= rd_entry.alt;
    sq_lat <= SQ_LAT_W'(dlat) * SQ_LAT_W'(dlat);
    sq_lon <= SQ_LON_W'(dlon) * SQ_LON_W'(dlon);
    alt3 <= alt2;
    sq_sum <= DIST_W'(sq_lat) + DIST_W'(sq_lon);
    alt4 <= alt3;
  end

  // strict less-than keeps the earliest entry on a tie
  always_ff @(posedge clk) begin
    if (rst || cmd.scan_start) begin
      have <= 1'b0;
    end else if (v4 && (!have || sq_sum < best)) begin
      have <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (v4 && (!have || sq_sum < best)) begin
      best     <= sq_sum;
      best_alt <= alt4;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_count <= COUNT_W'(count);
      if (q_op == OP_QUERY) begin
        if (count == '0) begin
          out_alt    <= '0;
          out_status <= STATUS_EMPTY;
        end else begin
          out_alt    <= best_alt;
          out_status <= STATUS_MATCHED;
        end
      end else begin
        out_alt    <= '0;
        out_status <= load_status;
      end
    end
  end

  assign stat.is_query   = (q_op == OP_QUERY);
  assign stat.count_zero = (count == '0);
  assign stat.scan_last  = ((CNT_W'(scan_idx) + CNT_W'(1)) == count);
  assign stat.pipe_busy  = v1 || v2 || v3 || v4;
  assign stat.out_free   = !out_valid || out_ready;

endmodule

@@ hw/rtl/nearest_point_altitude_lookup_unit.sv @@
// Nearest point altitude lookup.
// Input stream s_*: one transfer per item. s_tuser is the opcode (0 load, 1 query).
// A load appends {latitude, longitude, altitude} to a 256-entry table when the
// altitude is positive and the table has room. A query scans every stored
// entry and returns the altitude of the one nearest in squared 2D distance,
// the earliest entry winning a tie.
// Output stream m_*: exactly one result transfer per input transfer.
// Steps: an accepted item is captured, then decided; a load writes the table
// and a query scans it (skipped on an empty table) and waits for the pipeline
// to drain; the result is then pushed into the output register. The scan reads
// one table entry per cycle through the single memory read port, then a
// four-stage difference/square/sum/compare pipeline drains.
// One item at a time: s_tready is high only while the block is idle, so the
// next item is not taken until the last one's result is pushed.
// Results sit in an output register; the next item is accepted while it
// waits, and that item's result stalls until the register is taken.
// Reset (rst, synchronous): the table is emptied (entry count zero), the
// output register is emptied and the block is ready for a new item.
module nearest_point_altitude_lookup_unit
  import npal_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // [29:0] latitude, [60:30] longitude, [85:61] altitude_in, [87:86] zero
  input  logic [S_TDATA_W-1:0] s_tdata,
  // [0] opcode
  input  logic                 s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // [23:0] altitude_out, [26:24] status, [35:27] entry_count, [39:36] zero
  output logic [M_TDATA_W-1:0] m_tdata
);

  ctrl_cmd_t           cmd;
  dp_status_t          stat;
  logic [ALT_W-1:0]    out_alt;
  logic [STATUS_W-1:0] out_status;
  logic [COUNT_W-1:0]  out_count;

  npal_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  npal_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_opcode  (s_tuser),
    .in_lat     (s_tdata[LAT_W-1:0]),
    .in_lon     (s_tdata[LAT_W+LON_W-1:LAT_W]),
    .in_alt     (s_tdata[LAT_W+LON_W+ALT_IN_W-1:LAT_W+LON_W]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_alt    (out_alt),
    .out_status (out_status),
    .out_count  (out_count)
  );

  assign m_tdata = M_TDATA_W'({out_count, out_status, out_alt});

endmodule

@@ hw/rtl/npal_checker.sv @@
module npal_checker
  import npal_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic [S_TDATA_W-1:0] s_tdata,
  input logic                 s_tuser,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata
);

  logic [STATUS_W-1:0] r_status;
  logic [COUNT_W-1:0]  r_count;
  logic [ALT_W-1:0]    r_alt;

  assign r_alt    = m_tdata[ALT_W-1:0];
  assign r_status = m_tdata[ALT_W+STATUS_W-1:ALT_W];
  assign r_count  = m_tdata[ALT_W+STATUS_W+COUNT_W-1:ALT_W+STATUS_W];

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result pending right after reset");

  // one item at a time: no second transfer in the cycle after a transfer
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while an item is at work");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result changed while stalled");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && r_status == STATUS_EMPTY) |-> (r_count == '0 && r_alt == '0))
    else $error("empty status with entries or altitude");

  a_load_no_alt: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (r_status == STATUS_STORED || r_status == STATUS_IGNORED
                  || r_status == STATUS_FULL)) |-> (r_alt == '0))
    else $error("load result carries an altitude");

endmodule

bind nearest_point_altitude_lookup_unit npal_checker u_npal_checker (.*);

@@ tb/npal_result_checker.sv @@
`timescale 1ns / 1ps
module npal_result_checker
  import npal_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  // [29:0] latitude, [60:30] longitude, [85:61] altitude_in, [87:86] zero
  input  logic [S_TDATA_W-1:0] s_tdata,
  // [0] opcode
  input  logic                 s_tuser,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  // [23:0] altitude_out, [26:24] status, [35:27] entry_count, [39:36] zero
  input  logic [M_TDATA_W-1:0] m_tdata,
  output int                   errors,
  output int                   pending,
  output int                   checked
);

  localparam int MAX_PRINTED = 40;

  typedef struct {
    logic [ALT_W-1:0]   alt;
    status_t            status;
    logic [COUNT_W-1:0] count;
  } lookup_result_t;

  // shadow of the point table
  logic signed [LAT_W-1:0] pt_lat [TABLE_DEPTH];
  logic signed [LON_W-1:0] pt_lon [TABLE_DEPTH];
  logic        [ALT_W-1:0] pt_alt [TABLE_DEPTH];
  int unsigned             stored_count;

  lookup_result_t expected_results [$];

  function automatic logic [63:0] sq_dist(input logic signed [LAT_W-1:0] lat_a,
                                          input logic signed [LAT_W-1:0] lat_b,
                                          input logic signed [LON_W-1:0] lon_a,
                                          input logic signed [LON_W-1:0] lon_b);
    longint dy;
    longint dx;
    dy = longint'(lat_a) - longint'(lat_b);
    dx = longint'(lon_a) - longint'(lon_b);
    // both squares are below 2^62, so the sum fits
    return 64'(dy * dy) + 64'(dx * dx);
  endfunction

  task automatic apply_item(input  logic                       op,
                            input  logic signed [LAT_W-1:0]    lat,
                            input  logic signed [LON_W-1:0]    lon,
                            input  logic signed [ALT_IN_W-1:0] alt_in,
                            output lookup_result_t             res);
    logic [63:0] best_d;
    logic [63:0] d;
    int unsigned i;
    res.alt = '0;
    if (op == OP_LOAD) begin
      if (alt_in <= 0) begin
        res.status = STATUS_IGNORED;
      end else if (stored_count >= TABLE_DEPTH) begin
        res.status = STATUS_FULL;
      end else begin
        pt_lat[stored_count] = lat;
        pt_lon[stored_count] = lon;
        pt_alt[stored_count] = alt_in[ALT_W-1:0];
        stored_count++;
        res.status = STATUS_STORED;
      end
    end else if (stored_count == 0) begin
      res.status = STATUS_EMPTY;
    end else begin
      best_d  = sq_dist(lat, pt_lat[0], lon, pt_lon[0]);
      res.alt = pt_alt[0];
      // strict less-than keeps the earliest entry on a tie
      for (i = 1; i < stored_count; i++) begin
        d = sq_dist(lat, pt_lat[i], lon, pt_lon[i]);
        if (d < best_d) begin
          best_d  = d;
          res.alt = pt_alt[i];
        end
      end
      res.status = STATUS_MATCHED;
    end
    res.count = COUNT_W'(stored_count);
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (errors < MAX_PRINTED) begin
      $display("mismatch at result %0d (t=%0t): %s got %0d expected %0d",
               checked, $realtime, what, got, want);
    end
    errors++;
  endtask

  always @(posedge clk) begin
    lookup_result_t want;
    lookup_result_t next_res;
    if (rst) begin
      errors       = 0;
      pending      = 0;
      checked      = 0;
      stored_count = 0;
      expected_results.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result transfer with no item pending", 1, 0);
        end else begin
          want = expected_results.pop_front();
          if (m_tdata[23:0] !== want.alt)
            report_mismatch("altitude_out", m_tdata[23:0], want.alt);
          if (m_tdata[26:24] !== want.status)
            report_mismatch("status", m_tdata[26:24], want.status);
          if (m_tdata[35:27] !== want.count)
            report_mismatch("entry_count", m_tdata[35:27], want.count);
          checked++;
        end
      end
      if (s_tvalid && s_tready) begin
        apply_item(s_tuser, s_tdata[29:0], s_tdata[60:30], s_tdata[85:61], next_res);
        expected_results.insert(expected_results.size(), next_res);
      end
      pending = expected_results.size();
    end
  end

endmodule

@@ tb/nearest_point_altitude_lookup_unit_tb.sv @@
`timescale 1ns / 1ps
module nearest_point_altitude_lookup_unit_tb;
  import npal_pkg::*;

  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int SETTLE_CYCLES = 30;

  localparam logic [LAT_W-1:0]    LAT_MAX = 30'h1FFF_FFFF;
  localparam logic [LAT_W-1:0]    LAT_MIN = 30'h2000_0000;
  localparam logic [LON_W-1:0]    LON_MAX = 31'h3FFF_FFFF;
  localparam logic [LON_W-1:0]    LON_MIN = 31'h4000_0000;
  localparam logic [ALT_IN_W-1:0] ALT_POS_MAX = 25'h0FF_FFFF;
  localparam logic [ALT_IN_W-1:0] ALT_NEG_MIN = 25'h100_0000;
  localparam logic [ALT_IN_W-1:0] ALT_NEG_ONE = 25'h1FF_FFFF;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;
  logic                 s_tuser;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;

  int errors;
  int pending;
  int checked;
  int cycle_count;

  bit steady;      // no idling on either side while set
  int stall_left;
  int roll;

  // coordinates of points that the table holds, used to aim queries
  logic [LAT_W-1:0] known_lat [TABLE_DEPTH];
  logic [LON_W-1:0] known_lon [TABLE_DEPTH];
  int known_count;
  int n_loads;
  int n_positive;
  int n_queries;

  nearest_point_altitude_lookup_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  npal_result_checker u_result_checker (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .errors   (errors),
    .pending  (pending),
    .checked  (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results still pending", cycle_count, pending);
    $display("status: fail");
    $finish;
  end

  // result side backpressure: mostly short stalls, a few long ones
  always @(negedge clk) begin
    if (steady) begin
      m_tready = 1'b1;
    end else if (stall_left > 0) begin
      m_tready = 1'b0;
      stall_left--;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 65) begin
        m_tready = 1'b1;
      end else begin
        m_tready   = 1'b0;
        stall_left = (roll < 97) ? $urandom_range(0, 3) : $urandom_range(20, 80);
      end
    end
  end

  task automatic send_item(input logic                op,
                           input logic [LAT_W-1:0]    lat,
                           input logic [LON_W-1:0]    lon,
                           input logic [ALT_IN_W-1:0] alt);
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tuser  = op;
    s_tdata  = S_TDATA_W'({alt, lon, lat});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (op == OP_LOAD) begin
      n_loads++;
      if ($signed(alt) > 0) begin
        n_positive++;
        if (known_count < TABLE_DEPTH) begin
          known_lat[known_count] = lat;
          known_lon[known_count] = lon;
          known_count++;
        end
      end
    end else begin
      n_queries++;
    end
  endtask

  task automatic idle_gap();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (steady || r < 60) n = 0;
    else if (r < 93) n = $urandom_range(1, 3);
    else n = $urandom_range(10, 60);
    if (n > 0) begin
      @(negedge clk);
      s_tvalid = 1'b0;
      s_tdata  = S_TDATA_W'({$urandom(), $urandom(), $urandom()});
      s_tuser  = 1'($urandom_range(0, 1));
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // small grid values make equal distances common
  function automatic logic [LAT_W-1:0] pick_lat();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return LAT_W'(int'($urandom_range(0, 12)) - 6);
    if (r < 80) return LAT_W'(int'($urandom_range(0, 754974720)) - 377487360);
    return LAT_W'($urandom());
  endfunction

  function automatic logic [LON_W-1:0] pick_lon();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return LON_W'(int'($urandom_range(0, 12)) - 6);
    if (r < 80) return LON_W'(longint'($urandom_range(0, 1509949440)) - 754974720);
    return LON_W'($urandom());
  endfunction

  function automatic logic [ALT_IN_W-1:0] pick_alt();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return ALT_IN_W'($urandom_range(1, 10000000));
    if (r < 76) return ($urandom_range(0, 1) != 0) ? ALT_POS_MAX : ALT_IN_W'(1);
    if (r < 86) return ALT_IN_W'(-int'($urandom_range(0, 1000000)));
    return ALT_IN_W'($urandom());
  endfunction

  task automatic send_random_load();
    send_item(OP_LOAD, pick_lat(), pick_lon(), pick_alt());
  endtask

  task automatic send_random_query();
    logic [LAT_W-1:0] lat;
    logic [LON_W-1:0] lon;
    int r;
    int k;
    r = $urandom_range(0, 99);
    if (known_count == 0 || r >= 70) begin
      lat = pick_lat();
      lon = pick_lon();
    end else begin
      k   = $urandom_range(0, known_count - 1);
      lat = known_lat[k];
      lon = known_lon[k];
      // exact hit on a stored point, or a small offset from one
      if (r >= 35) begin
        lat = lat + LAT_W'(int'($urandom_range(0, 2000)) - 1000);
        lon = lon + LON_W'(int'($urandom_range(0, 2000)) - 1000);
      end
    end
    send_item(OP_QUERY, lat, lon, ALT_IN_W'($urandom()));
  endtask

  initial begin
    int i;
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = OP_LOAD;
    m_tready    = 1'b0;
    steady      = 1'b0;
    stall_left  = 0;
    known_count = 0;
    n_loads     = 0;
    n_positive  = 0;
    n_queries   = 0;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    // empty table, non-positive altitudes
    send_item(OP_QUERY, '0, '0, ALT_IN_W'($urandom()));
    send_item(OP_LOAD, 30'd5, 31'd5, '0);
    send_item(OP_LOAD, 30'd5, 31'd5, ALT_NEG_ONE);
    send_item(OP_LOAD, 30'd5, 31'd5, ALT_NEG_MIN);
    send_item(OP_QUERY, '0, '0, '0);
    // coordinate corners and the widest distances
    send_item(OP_LOAD, LAT_MAX, LON_MIN, ALT_POS_MAX);
    send_item(OP_LOAD, LAT_MIN, LON_MAX, ALT_IN_W'(1));
    send_item(OP_QUERY, LAT_MIN, LON_MAX, '0);
    send_item(OP_QUERY, LAT_MAX, LON_MIN, ALT_IN_W'($urandom()));
    send_item(OP_QUERY, LAT_MAX, LON_MAX, ALT_NEG_ONE);
    // ties: earliest entry must win
    send_item(OP_LOAD, 30'd0, 31'd10, ALT_IN_W'(100));
    send_item(OP_LOAD, 30'd0, LON_W'(-10), ALT_IN_W'(200));
    send_item(OP_QUERY, '0, '0, '0);
    send_item(OP_LOAD, 30'd0, 31'd10, ALT_IN_W'(300));
    send_item(OP_QUERY, 30'd0, 31'd10, '0);
    send_item(OP_LOAD, 30'd3, 31'd4, ALT_IN_W'(500));
    send_item(OP_LOAD, LAT_W'(-4), 31'd3, ALT_IN_W'(600));
    send_item(OP_LOAD, 30'd5, 31'd0, ALT_IN_W'(700));
    send_item(OP_QUERY, '0, '0, '0);
    send_item(OP_QUERY, 30'd4, LON_W'(-3), '0);
    // edges of the nominal coordinate range
    send_item(OP_LOAD, 30'd377487360, LON_W'(-754974720), ALT_IN_W'(10000000));
    send_item(OP_QUERY, 30'd377487000, LON_W'(-754974000), '0);
    idle_gap();

    // table grows while queries hit it
    for (i = 0; i < 350; i++) begin
      if ($urandom_range(0, 99) < 35) send_random_load();
      else send_random_query();
      idle_gap();
    end
    wait_drained();

    // fill the table, then overflow it
    while (n_positive < TABLE_DEPTH + 20) begin
      if ($urandom_range(0, 99) < 20) send_random_query();
      else send_random_load();
      idle_gap();
    end
    wait_drained();

    // full table: queries scan every entry, further loads are dropped
    steady = 1'b1;
    for (i = 0; i < 700; i++) begin
      if (i == 150) steady = 1'b0;
      if ($urandom_range(0, 99) < 30) send_random_load();
      else send_random_query();
      idle_gap();
    end
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("covered %0d loads (%0d with positive altitude) and %0d queries, %0d results checked",
             n_loads, n_positive, n_queries, checked);
    $display("table filled to %0d entries, %0d loads arrived on a full table",
             known_count, n_positive - known_count);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", errors);
      $display("status: fail");
    end
    $finish;
  end

endmodule
